// ===== design/mbvq_pkg.sv =====
// Shared types, constants and arithmetic helpers of the MBVQ error-diffusion halftoner.
`default_nettype none

package mbvq_pkg;

  // Default and reset values.
  localparam int          MAX_WIDTH_DEF = 1024;
  localparam logic [10:0] WIDTH_RESET   = 11'd512;

  // Stored errors in 1/16 pixel units, saturated to 14 bits.
  typedef logic signed [13:0] err_t;
  // Corrected pixel values and errors before diffusion.
  typedef logic signed [14:0] val_t;
  // Threshold sums over up to three channels.
  typedef logic signed [16:0] sum_t;
  // Weighted error products.
  typedef logic signed [18:0] wide_t;

  localparam err_t  ERR_MIN = -14'sd8192;
  localparam err_t  ERR_MAX = 14'sd8191;
  localparam val_t  FULL    = 15'sd4080;
  localparam val_t  HALF    = 15'sd2048;
  localparam sum_t  FULL_S  = 17'sd4080;
  localparam sum_t  FULL2_S = 17'sd8160;
  localparam sum_t  HALF_S  = 17'sd2048;

  // Floyd-Steinberg weights and the rounding offset.
  localparam wide_t WGT_AHEAD  = 19'sd7;
  localparam wide_t WGT_SAME   = 19'sd5;
  localparam wide_t WGT_BEHIND = 19'sd3;
  localparam wide_t WGT_DIAG   = 19'sd1;
  localparam wide_t ROUND_HALF = 19'sd8;

  // Cube vertices: bit 2 red, bit 1 green, bit 0 blue.
  localparam logic [2:0] VTX_K = 3'd0;
  localparam logic [2:0] VTX_B = 3'd1;
  localparam logic [2:0] VTX_G = 3'd2;
  localparam logic [2:0] VTX_C = 3'd3;
  localparam logic [2:0] VTX_R = 3'd4;
  localparam logic [2:0] VTX_M = 3'd5;
  localparam logic [2:0] VTX_Y = 3'd6;
  localparam logic [2:0] VTX_W = 3'd7;

  typedef enum logic [2:0] {
    QUAD_CMYW = 3'd0,
    QUAD_MYGC = 3'd1,
    QUAD_RGMY = 3'd2,
    QUAD_KRGB = 3'd3,
    QUAD_RGBM = 3'd4,
    QUAD_CMGB = 3'd5
  } quad_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    err_t r;
    err_t g;
    err_t b;
  } pix_err_t;

  typedef struct packed {
    val_t r;
    val_t g;
    val_t b;
  } pix_val_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic [2:0] vertex;
    quad_e      quad;
    logic       last;
  } res_t;

  // Clamp a wide value into the stored error range.
  function automatic err_t sat_err(wide_t x);
    if (x < wide_t'(ERR_MIN)) return ERR_MIN;
    if (x > wide_t'(ERR_MAX)) return ERR_MAX;
    return err_t'(x);
  endfunction

  // Saturating add of a share onto a stored error.
  function automatic err_t add_sat(err_t a, wide_t b);
    return sat_err(wide_t'(a) + b);
  endfunction

  // Weighted share, floor((e*w + 8) / 16), i.e. rounded half up.
  function automatic wide_t share_of(val_t e, wide_t w);
    wide_t y;
    y = wide_t'(e) * w + ROUND_HALF;
    return y >>> 4;
  endfunction

  // Minimum-brightness-variation quadruple from the sum thresholds.
  function automatic quad_e pick_quad(val_t r, val_t g, val_t b);
    sum_t rg;
    sum_t gb;
    sum_t rgb;
    quad_e q;
    rg  = sum_t'(r) + sum_t'(g);
    gb  = sum_t'(g) + sum_t'(b);
    rgb = rg + sum_t'(b);
    if (rg > FULL_S) begin
      if (gb > FULL_S) q = (rgb > FULL2_S) ? QUAD_CMYW : QUAD_MYGC;
      else q = QUAD_RGMY;
    end else if (!(gb > FULL_S)) begin
      q = (rgb > FULL_S) ? QUAD_RGBM : QUAD_KRGB;
    end else begin
      q = QUAD_CMGB;
    end
    return q;
  endfunction

  // Vertex of the chosen quadruple, by a fixed decision tree per quadruple.
  function automatic logic [2:0] pick_vertex(quad_e q, val_t r, val_t g, val_t b);
    logic [2:0] v;
    sum_t       br;
    sum_t       rgb_alt;
    v       = VTX_K;
    br      = sum_t'(b) + sum_t'(r);
    rgb_alt = sum_t'(r) - sum_t'(g) + sum_t'(b);
    unique case (q)
      QUAD_CMYW: begin
        v = VTX_W;
        if (b < HALF && b <= r && b <= g) v = VTX_Y;
        if (g < HALF && g <= b && g <= r) v = VTX_M;
        if (r < HALF && r <= b && r <= g) v = VTX_C;
      end
      QUAD_MYGC: begin
        v = VTX_M;
        if (g >= b && r >= b) v = (r >= HALF) ? VTX_Y : VTX_G;
        if (g >= r && b >= r) v = (b >= HALF) ? VTX_C : VTX_G;
      end
      QUAD_RGMY: begin
        if (b > HALF) begin
          if (r > HALF) v = (b >= g) ? VTX_M : VTX_Y;
          else v = (sum_t'(g) > br) ? VTX_G : VTX_M;
        end else begin
          if (r >= HALF) v = (g >= HALF) ? VTX_Y : VTX_R;
          else v = (r >= g) ? VTX_R : VTX_G;
        end
      end
      QUAD_KRGB: begin
        v = VTX_K;
        if (b > HALF && b >= r && b >= g) v = VTX_B;
        if (g > HALF && g >= b && g >= r) v = VTX_G;
        if (r > HALF && r >= b && r >= g) v = VTX_R;
      end
      QUAD_RGBM: begin
        v = VTX_G;
        if (r > g && r >= b) v = (b < HALF) ? VTX_R : VTX_M;
        if (b > g && b >= r) v = (r < HALF) ? VTX_B : VTX_M;
      end
      default: begin
        if (b > HALF) begin
          if (r > HALF) v = (g >= r) ? VTX_C : VTX_M;
          else v = (g > HALF) ? VTX_C : VTX_B;
        end else begin
          if (r > HALF) v = (rgb_alt >= HALF_S) ? VTX_M : VTX_G;
          else v = (g >= b) ? VTX_G : VTX_B;
        end
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/mbvq_if.sv =====
// Valid/ready channel interfaces for pixels in and halftone results out.
`default_nettype none

interface mbvq_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_start, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input frame_start, output ready);
endinterface

interface mbvq_res_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic [2:0] quadruple_index;
  logic       row_end;

  modport source (output valid, output red_on, output green_on, output blue_on,
                  output quadruple_index, output row_end, input ready);
  modport sink   (input valid, input red_on, input green_on, input blue_on,
                  input quadruple_index, input row_end, output ready);
endinterface

`default_nettype wire

// ===== design/mbvq_decide.sv =====
// Error correction, quadruple choice, vertex choice and quantization error of one pixel.
`default_nettype none

module mbvq_decide import mbvq_pkg::*; (
  input  rgb_t       rgb_i,
  input  pix_err_t   stored_i,
  input  pix_err_t   ahead_i,
  output quad_e      quad_o,
  output logic [2:0] vertex_o,
  output pix_val_t   err_o
);

  pix_err_t tot;
  pix_val_t val;

  // Diffused error total, saturated, added to the scaled sample.
  always_comb begin
    tot.r = add_sat(stored_i.r, wide_t'(ahead_i.r));
    tot.g = add_sat(stored_i.g, wide_t'(ahead_i.g));
    tot.b = add_sat(stored_i.b, wide_t'(ahead_i.b));
    val.r = val_t'({rgb_i.r, 4'b0000}) + val_t'(tot.r);
    val.g = val_t'({rgb_i.g, 4'b0000}) + val_t'(tot.g);
    val.b = val_t'({rgb_i.b, 4'b0000}) + val_t'(tot.b);
  end

  // Quadruple and vertex decisions.
  assign quad_o   = pick_quad(val.r, val.g, val.b);
  assign vertex_o = pick_vertex(quad_o, val.r, val.g, val.b);

  // Quantization error per channel: corrected value minus chosen level.
  always_comb begin
    err_o.r = val.r - (vertex_o[2] ? FULL : val_t'(0));
    err_o.g = val.g - (vertex_o[1] ? FULL : val_t'(0));
    err_o.b = val.b - (vertex_o[0] ? FULL : val_t'(0));
  end

endmodule

`default_nettype wire

// ===== design/mbvq_error_diffusion_halftoner.sv =====
// A result is offered once its pixel has passed phases A and B into the output queue.
// A new pixel is taken only while stage 1 is empty or in phase B, since each pixel makes
// two reads (own column, then the neighbor below-behind) on the single read port of the
// error line memory. Reset clears position, direction and carries, sets image_width to 512
// and then sweeps every line memory entry to zero with no pixel taken; a frame_start pixel
// waits for the pipeline to drain and then for the same sweep.
`default_nettype none

module mbvq_error_diffusion_halftoner import mbvq_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mbvq_pix_if.sink         pix_i,
  mbvq_res_if.source       res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  // Configuration register
  logic [10:0] width_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_IMAGE_WIDTH);
  assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ? {21'd0, width_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_q <= pwdata[10:0];
    end
  end

  // Effective last column index, clamped to 2..MAX_WIDTH pixels.
  logic [CW-1:0] wm1;

  always_comb begin
    if (width_q < 11'd2) begin
      wm1 = CW'(1);
    end else if ({21'd0, width_q} > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width_q - 11'd1);
    end
  end

  // Scan position state and control registers
  logic [CW-1:0] cp_q;
  logic          rev_q;
  logic          clr_q;
  logic [CW-1:0] clr_cnt_q;
  pix_err_t      ahead_q;
  pix_err_t      bh_q;

  // Stage 1: read phases A and B
  logic          s1_valid_q;
  logic          s1_phb_q;
  logic          s1_frame_q;
  rgb_t          s1_rgb_q;
  logic [CW-1:0] s1_col_q;
  logic [CW-1:0] s1_nb_q;
  logic          s1_nbv_q;
  logic          s1_last_q;

  // Stage 2: write phases C and D
  logic          s2_phc_q;
  logic          s2_phd_q;
  pix_val_t      s2_e_q;
  logic [CW-1:0] s2_col_q;
  logic [CW-1:0] s2_nb_q;
  logic          s2_nbv_q;
  logic          s2_last_q;
  pix_err_t      s2_wb_q;

  // Line memory and its forwarding registers
  pix_err_t      err_mem_q [MAX_WIDTH];
  pix_err_t      rd_q;
  logic          pw_v_q;
  logic [CW-1:0] pw_a_q;
  pix_err_t      pw_d_q;
  logic          mem_we;
  logic [CW-1:0] mem_wa;
  pix_err_t      mem_wd;
  logic [CW-1:0] mem_ra;

  // Output queue
  res_t          oq_q [2];
  logic          oq_wr_q;
  logic          oq_rd_q;
  logic [1:0]    oq_cnt_q;
  logic          oq_push;
  logic          oq_pop;

  logic          pix_acc;
  logic          start_a;
  logic          start_clr;

  // Column of an incoming pixel, its neighbor below-behind and the row end.
  logic [CW-1:0] cp_eff;
  logic          rev_eff;
  logic [CW-1:0] cpc;
  logic [CW-1:0] col_new;
  logic [CW-1:0] nb_new_col;
  logic          nbv_new;
  logic          last_new;

  always_comb begin
    cp_eff     = pix_i.frame_start ? '0 : cp_q;
    rev_eff    = pix_i.frame_start ? 1'b0 : rev_q;
    cpc        = (cp_eff > wm1) ? wm1 : cp_eff;
    col_new    = rev_eff ? (wm1 - cpc) : cpc;
    last_new   = (cpc == wm1);
    nb_new_col = rev_eff ? (col_new + CW'(1)) : (col_new - CW'(1));
    nbv_new    = rev_eff ? (col_new != wm1) : (col_new != '0);
  end

  // Handshake and sequencing
  assign pix_i.ready = !clr_q && (!s1_valid_q || s1_phb_q);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign start_a     = s1_valid_q && !s1_phb_q && !s1_frame_q && !clr_q && (oq_cnt_q != 2'd2);
  assign start_clr   = s1_valid_q && s1_frame_q && !clr_q && !s2_phc_q && !s2_phd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q       <= '0;
      rev_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_phb_q   <= 1'b0;
      s1_frame_q <= 1'b0;
      s2_phc_q   <= 1'b0;
      s2_phd_q   <= 1'b0;
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (pix_acc) begin
        cp_q  <= last_new ? '0 : (cpc + CW'(1));
        rev_q <= last_new ? !rev_eff : rev_eff;
      end
      if (pix_acc) begin
        s1_valid_q <= 1'b1;
        s1_frame_q <= pix_i.frame_start;
      end else if (s1_phb_q) begin
        s1_valid_q <= 1'b0;
      end else if (start_clr) begin
        s1_frame_q <= 1'b0;
      end
      s1_phb_q <= start_a;
      s2_phc_q <= s1_phb_q;
      s2_phd_q <= s2_phc_q;
      if (start_clr) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
      end else if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + CW'(1);
        if (clr_cnt_q == CW'(MAX_WIDTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // Stage 1 payload, loaded on a pixel transfer.
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_rgb_q  <= '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
      s1_col_q  <= col_new;
      s1_nb_q   <= nb_new_col;
      s1_nbv_q  <= nbv_new;
      s1_last_q <= last_new;
    end
  end

  // Phase B: own column data, corrected for writes still in flight.
  pix_err_t   cur_fwd;
  quad_e      dec_quad;
  logic [2:0] dec_vertex;
  pix_val_t   dec_err;

  always_comb begin
    if (mem_we && (mem_wa == s1_col_q)) begin
      cur_fwd = mem_wd;
    end else if (pw_v_q && (pw_a_q == s1_col_q)) begin
      cur_fwd = pw_d_q;
    end else begin
      cur_fwd = rd_q;
    end
  end

  mbvq_decide u_decide (
    .rgb_i    (s1_rgb_q),
    .stored_i (cur_fwd),
    .ahead_i  (ahead_q),
    .quad_o   (dec_quad),
    .vertex_o (dec_vertex),
    .err_o    (dec_err)
  );

  always_ff @(posedge clk_i) begin
    if (s1_phb_q) begin
      s2_e_q    <= dec_err;
      s2_col_q  <= s1_col_q;
      s2_nb_q   <= s1_nb_q;
      s2_nbv_q  <= s1_nbv_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Phase C: shares of the error, update of the neighbor entry and of the carries.
  pix_err_t nb_fwd;
  pix_err_t nb_upd;
  pix_err_t wb_new;
  pix_err_t ahead_new;
  pix_err_t bh_new;

  always_comb begin
    nb_fwd      = (pw_v_q && (pw_a_q == s2_nb_q)) ? pw_d_q : rd_q;
    nb_upd.r    = add_sat(nb_fwd.r, share_of(s2_e_q.r, WGT_BEHIND));
    nb_upd.g    = add_sat(nb_fwd.g, share_of(s2_e_q.g, WGT_BEHIND));
    nb_upd.b    = add_sat(nb_fwd.b, share_of(s2_e_q.b, WGT_BEHIND));
    wb_new.r    = add_sat(bh_q.r, share_of(s2_e_q.r, WGT_SAME));
    wb_new.g    = add_sat(bh_q.g, share_of(s2_e_q.g, WGT_SAME));
    wb_new.b    = add_sat(bh_q.b, share_of(s2_e_q.b, WGT_SAME));
    ahead_new.r = sat_err(share_of(s2_e_q.r, WGT_AHEAD));
    ahead_new.g = sat_err(share_of(s2_e_q.g, WGT_AHEAD));
    ahead_new.b = sat_err(share_of(s2_e_q.b, WGT_AHEAD));
    bh_new.r    = sat_err(share_of(s2_e_q.r, WGT_DIAG));
    bh_new.g    = sat_err(share_of(s2_e_q.g, WGT_DIAG));
    bh_new.b    = sat_err(share_of(s2_e_q.b, WGT_DIAG));
  end

  always_ff @(posedge clk_i) begin
    if (s2_phc_q) begin
      s2_wb_q <= wb_new;
    end
  end

  // Carries to the next pixel; dropped at a row end and at a frame start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ahead_q <= '0;
      bh_q    <= '0;
    end else if (start_clr) begin
      ahead_q <= '0;
      bh_q    <= '0;
    end else if (s2_phc_q) begin
      ahead_q <= s2_last_q ? '0 : ahead_new;
      bh_q    <= s2_last_q ? '0 : bh_new;
    end
  end

  // Memory port selection: clearing sweep, own column (phase D), neighbor (phase C).
  always_comb begin
    mem_we = clr_q || s2_phd_q || (s2_phc_q && s2_nbv_q);
    if (clr_q) begin
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else if (s2_phd_q) begin
      mem_wa = s2_col_q;
      mem_wd = s2_wb_q;
    end else begin
      mem_wa = s2_nb_q;
      mem_wd = nb_upd;
    end
    mem_ra = s1_phb_q ? s1_nb_q : s1_col_q;
  end

  // Line memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      err_mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= err_mem_q[mem_ra];
  end

  // Last write, held in registers so that a read of the same entry sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_v_q <= 1'b0;
    end else begin
      pw_v_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_a_q <= mem_wa;
    pw_d_q <= mem_wd;
  end

  // Two-entry result queue, filled at the end of phase B.
  assign oq_push = s1_phb_q;
  assign oq_pop  = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) oq_wr_q <= !oq_wr_q;
      if (oq_pop) oq_rd_q <= !oq_rd_q;
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (!oq_push && oq_pop) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= '{vertex: dec_vertex, quad: dec_quad, last: s1_last_q};
    end
  end

  // Result channel
  res_t oq_head;

  assign oq_head               = oq_q[oq_rd_q];
  assign res_o.valid           = (oq_cnt_q != 2'd0);
  assign res_o.red_on          = oq_head.vertex[2];
  assign res_o.green_on        = oq_head.vertex[1];
  assign res_o.blue_on         = oq_head.vertex[0];
  assign res_o.quadruple_index = oq_head.quad;
  assign res_o.row_end         = oq_head.last;

endmodule

`default_nettype wire

// ===== sim/halftone_checker.sv =====
// Checker for the halftoner: mirrors the width register, predicts each halftone dot and compares.
module halftone_checker import mbvq_pkg::*; #(
  parameter logic [2:0] WIDTH_ADDR = 3'd0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mbvq_pix_if              pix_i,
  mbvq_res_if              res_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  output int               mismatch_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = MAX_WIDTH_DEF;

  // One predicted halftone dot.
  typedef struct packed {
    logic  red;
    logic  green;
    logic  blue;
    quad_e quad;
    logic  row_end;
  } dot_t;

  // Error store with a guard column on each side, plus the carries along the row.
  err_t        below_row   [0:COLS+1][0:2];
  err_t        carry_ahead [0:2];
  err_t        carry_diag  [0:2];
  int          column;
  logic        right_to_left;
  logic [10:0] width_shadow = WIDTH_RESET;
  dot_t        awaited_dots [$];

  function automatic err_t clamp_err(int x);
    if (x < int'(ERR_MIN)) return ERR_MIN;
    if (x > int'(ERR_MAX)) return ERR_MAX;
    return err_t'(x);
  endfunction

  // Weighted share in 1/16 units, rounded half up (arithmetic shift floors).
  function automatic int fs_share(int e, int wt);
    return (e * wt + 8) >>> 4;
  endfunction

  function automatic quad_e choose_quad(int r, int g, int b);
    int full;
    full = int'(FULL);
    if (r + g > full) begin
      if (g + b > full) return (r + g + b > 2 * full) ? QUAD_CMYW : QUAD_MYGC;
      return QUAD_RGMY;
    end
    if (g + b <= full) return (r + g + b > full) ? QUAD_RGBM : QUAD_KRGB;
    return QUAD_CMGB;
  endfunction

  function automatic logic [2:0] choose_vertex(quad_e q, int r, int g, int b);
    int         half;
    logic [2:0] v;
    half = int'(HALF);
    v    = VTX_K;
    case (q)
      QUAD_CMYW: begin
        v = VTX_W;
        if (b < half && b <= r && b <= g) v = VTX_Y;
        if (g < half && g <= b && g <= r) v = VTX_M;
        if (r < half && r <= b && r <= g) v = VTX_C;
      end
      QUAD_MYGC: begin
        v = VTX_M;
        if (g >= b && r >= b) v = (r >= half) ? VTX_Y : VTX_G;
        if (g >= r && b >= r) v = (b >= half) ? VTX_C : VTX_G;
      end
      QUAD_RGMY: begin
        if (b > half) begin
          if (r > half) v = (b >= g) ? VTX_M : VTX_Y;
          else v = (g > b + r) ? VTX_G : VTX_M;
        end else if (r >= half) begin
          v = (g >= half) ? VTX_Y : VTX_R;
        end else begin
          v = (r >= g) ? VTX_R : VTX_G;
        end
      end
      QUAD_KRGB: begin
        v = VTX_K;
        if (b > half && b >= r && b >= g) v = VTX_B;
        if (g > half && g >= b && g >= r) v = VTX_G;
        if (r > half && r >= b && r >= g) v = VTX_R;
      end
      QUAD_RGBM: begin
        v = VTX_G;
        if (r > g && r >= b) v = (b < half) ? VTX_R : VTX_M;
        if (b > g && b >= r) v = (r < half) ? VTX_B : VTX_M;
      end
      default: begin
        if (b > half) begin
          if (r > half) v = (g >= r) ? VTX_C : VTX_M;
          else v = (g > half) ? VTX_C : VTX_B;
        end else if (r > half) begin
          v = (r - g + b >= half) ? VTX_M : VTX_G;
        end else begin
          v = (g >= b) ? VTX_G : VTX_B;
        end
      end
    endcase
    return v;
  endfunction

  // Frame start: all errors, the column and the scan direction go back to zero.
  task automatic clear_errors();
    int i;
    int k;
    for (i = 0; i <= COLS + 1; i++)
      for (k = 0; k < 3; k++) below_row[i][k] = '0;
    for (k = 0; k < 3; k++) begin
      carry_ahead[k] = '0;
      carry_diag[k]  = '0;
    end
    column        = 0;
    right_to_left = 1'b0;
  endtask

  // Correct one pixel, quantize it and spread its error in serpentine order.
  task automatic diffuse_pixel(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input logic fs, output dot_t dot);
    int         w;
    int         c;
    int         idx;
    int         k;
    int         e;
    int         s1;
    int         s3;
    int         s5;
    int         s7;
    int         sample [0:2];
    int         level  [0:2];
    quad_e      quad;
    logic [2:0] vtx;
    if (fs) clear_errors();
    w = int'(width_shadow);
    if (w < 2) w = 2;
    if (w > COLS) w = COLS;
    // A width lowered mid-row turns the current pixel into the last one.
    if (column > w - 1) column = w - 1;
    c         = right_to_left ? (w - 1 - column) : column;
    idx       = c + 1;
    sample[0] = int'(red);
    sample[1] = int'(green);
    sample[2] = int'(blue);
    for (k = 0; k < 3; k++)
      level[k] = sample[k] * 16
               + int'(clamp_err(int'(below_row[idx][k]) + int'(carry_ahead[k])));
    quad = choose_quad(level[0], level[1], level[2]);
    vtx  = choose_vertex(quad, level[0], level[1], level[2]);
    for (k = 0; k < 3; k++) begin
      e  = level[k] - (vtx[2 - k] ? int'(FULL) : 0);
      s7 = fs_share(e, 7);
      s5 = fs_share(e, 5);
      s3 = fs_share(e, 3);
      s1 = fs_share(e, 1);
      carry_ahead[k] = clamp_err(s7);
      // The share behind is dropped where it would fall outside the image.
      if (!right_to_left) begin
        if (c >= 1) below_row[idx - 1][k] = clamp_err(int'(below_row[idx - 1][k]) + s3);
      end else if (c + 1 <= w - 1) begin
        below_row[idx + 1][k] = clamp_err(int'(below_row[idx + 1][k]) + s3);
      end
      below_row[idx][k] = clamp_err(s5 + int'(carry_diag[k]));
      carry_diag[k]     = err_t'(s1);
    end
    dot.row_end = (column == w - 1);
    if (dot.row_end) begin
      for (k = 0; k < 3; k++) begin
        carry_ahead[k] = '0;
        carry_diag[k]  = '0;
      end
      column        = 0;
      right_to_left = !right_to_left;
    end else begin
      column++;
    end
    dot.red   = vtx[2];
    dot.green = vtx[1];
    dot.blue  = vtx[0];
    dot.quad  = quad;
  endtask

  task automatic report_mismatch(string what, int got, int want_v);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want_v);
    mismatch_count_o++;
  endtask

  // Register mirror, result comparison, then prediction of newly taken pixels.
  always @(posedge clk_i or negedge rst_ni) begin
    dot_t want;
    dot_t fresh;
    if (!rst_ni) begin
      clear_errors();
      width_shadow = WIDTH_RESET;
      awaited_dots.delete();
    end else begin
      if (psel && penable && pready && paddr == WIDTH_ADDR) begin
        if (pwrite) begin
          width_shadow = pwdata[10:0];
        end else if (prdata[10:0] !== width_shadow) begin
          report_mismatch("image_width readback", int'(prdata[10:0]), int'(width_shadow));
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (awaited_dots.size() == 0) begin
          report_mismatch("result with no pixel pending", 1, 0);
        end else begin
          want = awaited_dots.pop_front();
          if (res_i.red_on !== want.red)
            report_mismatch("red_on", int'(res_i.red_on), int'(want.red));
          if (res_i.green_on !== want.green)
            report_mismatch("green_on", int'(res_i.green_on), int'(want.green));
          if (res_i.blue_on !== want.blue)
            report_mismatch("blue_on", int'(res_i.blue_on), int'(want.blue));
          if (res_i.quadruple_index !== want.quad)
            report_mismatch("quadruple_index", int'(res_i.quadruple_index), int'(want.quad));
          if (res_i.row_end !== want.row_end)
            report_mismatch("row_end", int'(res_i.row_end), int'(want.row_end));
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        diffuse_pixel(pix_i.red_in, pix_i.green_in, pix_i.blue_in, pix_i.frame_start, fresh);
        awaited_dots.push_back(fresh);
      end
    end
    pending_o = awaited_dots.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives pixels, result back-pressure and register writes, and gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbvq_pkg::*;

  localparam logic [2:0] ADDR_IMAGE_WIDTH = 3'd0;
  localparam int         ITEM_TARGET      = 1450;
  localparam int         CALM_FROM        = 1300;
  localparam int         QUIET_LIMIT      = 8000;
  localparam int         END_CYCLES       = 20;

  typedef enum int {MODE_RANDOM, MODE_EDGES, MODE_SMOOTH, MODE_SOLID} tone_mode_e;

  // Blacks, whites, primaries, secondaries and levels around the halfway threshold.
  localparam logic [23:0] DIRECTED_RGB [20] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h808080, 24'h7F7F7F,
    24'h800000, 24'h008080, 24'h80FF80, 24'hFF8000, 24'h0080FF,
    24'h408040, 24'hC0C0C0, 24'h010101, 24'hFEFEFE, 24'h804020
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int sent;
  int quiet;
  int stall_left;
  bit idle_on;
  int stall_pct;
  int gap_pct;

  mbvq_pix_if pix ();
  mbvq_res_if res ();

  mbvq_error_diffusion_halftoner dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  halftone_checker #(.WIDTH_ADDR(ADDR_IMAGE_WIDTH)) halftone_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix_i            (pix),
    .res_i            (res),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result back-pressure in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 13);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL mbvq_error_diffusion_halftoner");
      $finish;
    end
  end

  // Register write followed by a readback; called at a falling edge.
  task automatic write_image_width(logic [10:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_IMAGE_WIDTH;
    pwdata  <= {21'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one pixel, optionally after a gap, and return at the falling edge after its transfer.
  task automatic send_pixel(rgb_t px, logic fs);
    int gap;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.red_in      <= px.r;
    pix.green_in    <= px.g;
    pix.blue_in     <= px.b;
    pix.frame_start <= fs;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Hold the sender until every expected dot has come back.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_level(tone_mode_e mode, logic [7:0] base);
    logic [7:0] edges [6];
    int         v;
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    case (mode)
      MODE_EDGES: return edges[$urandom_range(0, 5)];
      MODE_SMOOTH: begin
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
      end
      MODE_SOLID: return base;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly narrow images, with the register extremes and full width now and then.
  function automatic logic [10:0] pick_width();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 11'd0;
    if (roll < 9) return 11'd1;
    if (roll < 13) return 11'd2047;
    if (roll < 19) return 11'd1024;
    if (roll < 25) return 11'($urandom);
    if (roll < 32) return 11'd2;
    return 11'($urandom_range(3, 12));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 60;
    endcase
  endfunction

  // One stretch of pixels at a fixed width and tone style.
  task automatic run_phase(logic [10:0] width_val);
    tone_mode_e mode;
    rgb_t       base;
    rgb_t       px;
    logic       fs;
    int         count;
    int         i;
    drain();
    write_image_width(width_val);
    mode      = tone_mode_e'($urandom_range(0, 3));
    base      = rgb_t'(24'($urandom));
    stall_pct <= pick_pct();
    gap_pct   <= pick_pct();
    count     = (width_val >= 100) ? $urandom_range(20, 120) : $urandom_range(6, 50);
    for (i = 0; i < count; i++) begin
      px.r = pick_level(mode, base.r);
      px.g = pick_level(mode, base.g);
      px.b = pick_level(mode, base.b);
      fs   = (i == 0) ? ($urandom_range(0, 99) < 40) : ($urandom_range(0, 79) == 0);
      send_pixel(px, fs);
    end
    pix.valid <= 1'b0;
  endtask

  initial begin
    int i;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = ADDR_IMAGE_WIDTH;
    pwdata          = '0;
    pix.valid       = 1'b0;
    pix.red_in      = '0;
    pix.green_in    = '0;
    pix.blue_in     = '0;
    pix.frame_start = 1'b0;
    res.ready       = 1'b1;
    idle_on         = 1'b1;
    stall_pct       = 0;
    gap_pct         = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed colors over short rows, then a width cut while mid-row.
    write_image_width(11'd4);
    for (i = 0; i < 10; i++) send_pixel(rgb_t'(DIRECTED_RGB[i]), i == 0);
    pix.valid <= 1'b0;
    drain();
    write_image_width(11'd0);
    for (i = 10; i < 20; i++) send_pixel(rgb_t'(DIRECTED_RGB[i]), 1'b0);
    pix.valid <= 1'b0;

    // Random frames with idling on both sides, then a last stretch without any.
    while (sent < CALM_FROM) run_phase(pick_width());
    idle_on <= 1'b0;
    while (sent < ITEM_TARGET) run_phase(pick_width());

    drain();
    repeat (END_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS mbvq_error_diffusion_halftoner");
    end else begin
      $display("FAIL mbvq_error_diffusion_halftoner");
    end
    $finish;
  end

endmodule
